// File: src/mad_pkg.sv
// Shared types, constants and saturation helper for the modulated allpass delay.
package mad_pkg;

  // Field widths fixed by the sample and control formats
  localparam int SAMPLE_W   = 24;
  localparam int LFO_W      = 21;
  localparam int TARGET_W   = 22;
  localparam int GAIN_W     = 16;
  localparam int SMOOTH_W   = 38;
  localparam int PROD_W     = 40;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd1;

  // One-pole smoother coefficients, Q0.16
  localparam logic [15:0] SMOOTH_KEEP = 16'd65503;
  localparam logic [15:0] SMOOTH_TAKE = 16'd33;

  // The integer delay lies strictly inside (-WHOLE_MAX, WHOLE_MAX)
  localparam int WHOLE_MAX  = 20480;

  // Tap arithmetic: biased index width and reciprocal shift
  localparam int TAP_CALC_W = 18;
  localparam int RECIP_SH   = 18;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  // Datapath commands, one per controller step
  typedef struct packed {
    logic load_in;
    logic smooth;
    logic calc_off;
    logic calc_quot;
    logic calc_tap;
    logic mem_rd;
    logic mul_d;
    logic write_w;
    logic mul_w;
    logic load_out;
  } mad_cmd_t;

  // Clamp a 26-bit signed value to the 24-bit sample range
  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [25:0] v);
    logic signed [SAMPLE_W-1:0] res;
    if (v > 26'(SAMPLE_MAX)) begin
      res = SAMPLE_MAX;
    end else if (v < 26'(SAMPLE_MIN)) begin
      res = SAMPLE_MIN;
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: src/mad_ctrl.sv
// Step sequencer for the modulated allpass delay.
module mad_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output mad_pkg::mad_cmd_t cmd_o
);
  import mad_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_OFFS,
    ST_QUOT,
    ST_TAP,
    ST_READ,
    ST_MULD,
    ST_WRW,
    ST_MULW,
    ST_OUT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;
  logic   accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // Decode the step into datapath commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.load_in   = accept;
    cmd_o.smooth    = (state_r == ST_SMOOTH);
    cmd_o.calc_off  = (state_r == ST_OFFS);
    cmd_o.calc_quot = (state_r == ST_QUOT);
    cmd_o.calc_tap  = (state_r == ST_TAP);
    cmd_o.mem_rd    = (state_r == ST_READ);
    cmd_o.mul_d     = (state_r == ST_MULD);
    cmd_o.write_w   = (state_r == ST_WRW);
    cmd_o.mul_w     = (state_r == ST_MULW);
    cmd_o.load_out  = (state_r == ST_OUT) && out_free;
  end

  // Advance the sequence and track the output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Raise the word when the last step completes, drop it once taken
      if ((state_r == ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE:   if (accept) state_r <= ST_SMOOTH;
        ST_SMOOTH: state_r <= ST_OFFS;
        ST_OFFS:   state_r <= ST_QUOT;
        ST_QUOT:   state_r <= ST_TAP;
        ST_TAP:    state_r <= ST_READ;
        ST_READ:   state_r <= ST_MULD;
        ST_MULD:   state_r <= ST_WRW;
        ST_WRW:    state_r <= ST_MULW;
        ST_MULW:   state_r <= ST_OUT;
        ST_OUT:    if (out_free) state_r <= ST_IDLE;
        default:   state_r <= ST_IDLE;
      endcase
    end
  end

  // A new result never overwrites an undelivered word
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load_out |-> (!out_valid_r || !out_stall))
    else $error("result loaded over an undelivered word");

  // An accepted word starts the sequence
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SMOOTH))
    else $error("accepted word did not start the sequence");

  // At most one datapath step per cycle
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd_o))
    else $error("more than one datapath step issued");

endmodule

// File: src/mad_dp.sv
// Datapath of the modulated allpass delay: smoother, tap arithmetic, delay memory, multiplier.
module mad_dp #(
  parameter int DELAY_DEPTH = 16384
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  mad_pkg::mad_cmd_t                         cmd,
  input  logic signed [mad_pkg::SAMPLE_W-1:0]       in_audio_in,
  input  logic signed [mad_pkg::LFO_W-1:0]          in_mod_offset,
  input  logic                                      cfg_we,
  input  logic        [mad_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic        [mad_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic signed [mad_pkg::SAMPLE_W-1:0]       out_audio_out
);
  import mad_pkg::*;

  localparam int AW    = $clog2(DELAY_DEPTH);
  // Multiple of the depth that keeps the biased tap index non-negative
  localparam int OFF   = ((WHOLE_MAX + DELAY_DEPTH - 1) / DELAY_DEPTH) * DELAY_DEPTH;
  localparam int RECIP = (1 << RECIP_SH) / DELAY_DEPTH;

  // Configuration and state registers
  logic        [TARGET_W-1:0]   target_r;
  logic signed [GAIN_W-1:0]     gain_r;
  logic        [SMOOTH_W-1:0]   s_r;
  logic        [AW-1:0]         wp_r;
  logic                         wrap_r;

  // Working registers
  logic signed [SAMPLE_W-1:0]   x_r;
  logic signed [LFO_W-1:0]      lfo_r;
  logic        [TAP_CALC_W-1:0] v_r;
  logic        [TAP_CALC_W-1:0] q_r;
  logic        [AW-1:0]         tap_r;
  logic        [SAMPLE_W-1:0]   rd_r;
  logic                         rd_ok_r;
  logic signed [SAMPLE_W-1:0]   d_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [SAMPLE_W-1:0]   w_r;
  logic signed [SAMPLE_W-1:0]   out_r;

  logic        [SAMPLE_W-1:0]   mem [DELAY_DEPTH];

  // Combinational intermediates
  logic        [53:0]           keep_prod;
  logic        [27:0]           take_prod;
  logic        [53:0]           smooth_sum;
  logic        [AW-1:0]         wp_inc;
  logic signed [39:0]           dsum;
  logic signed [39:0]           dadj;
  logic signed [15:0]           whole;
  logic        [19:0]           v_full;
  logic        [35:0]           qprod;
  logic        [35:0]           qd;
  logic        [35:0]           rem_full;
  logic        [TAP_CALC_W-1:0] rem;
  logic        [AW-1:0]         tap_nxt;
  logic                         rd_ok_nxt;
  logic signed [SAMPLE_W-1:0]   d_sel;
  logic signed [SAMPLE_W-1:0]   mul_op;
  logic signed [PROD_W-1:0]     prod_nxt;
  logic signed [24:0]           prod_q15;
  logic signed [SAMPLE_W-1:0]   w_nxt;
  logic signed [SAMPLE_W-1:0]   y_nxt;

  // One-pole smoother toward the target delay
  assign keep_prod  = {16'b0, s_r} * {38'b0, SMOOTH_KEEP};
  assign take_prod  = {6'b0, target_r} * {12'b0, SMOOTH_TAKE};
  assign smooth_sum = keep_prod + {10'b0, take_prod, 16'b0};

  // Advance and wrap the write pointer
  assign wp_inc = (wp_r == AW'(DELAY_DEPTH - 1)) ? '0 : wp_r + AW'(1);

  // Integer delay, truncated toward zero, then biased tap index
  assign dsum   = $signed({2'b0, s_r}) + $signed({{3{lfo_r[LFO_W-1]}}, lfo_r, 16'b0});
  assign dadj   = dsum + (dsum[39] ? 40'sd16777215 : 40'sd0);
  assign whole  = $signed(dadj[39:24]);
  assign v_full = 20'(wp_r) + 20'(OFF) - 20'(whole);

  // Quotient by reciprocal, remainder with one correction
  assign qprod    = {18'b0, v_r} * 36'(RECIP);
  assign qd       = {18'b0, q_r} * 36'(DELAY_DEPTH);
  assign rem_full = {18'b0, v_r} - qd;
  assign rem      = rem_full[TAP_CALC_W-1:0];
  assign tap_nxt  = (rem >= TAP_CALC_W'(DELAY_DEPTH)) ?
                    AW'(rem - TAP_CALC_W'(DELAY_DEPTH)) : AW'(rem);

  // Entries not yet written since reset read as zero
  assign rd_ok_nxt = wrap_r || ((tap_r != '0) && ((tap_r < wp_r) || (wp_r == '0)));

  // Shared gain multiplier and allpass sums
  assign d_sel    = rd_ok_r ? $signed(rd_r) : '0;
  assign mul_op   = cmd.mul_w ? w_r : d_sel;
  assign prod_nxt = PROD_W'(mul_op) * PROD_W'(gain_r);
  assign prod_q15 = $signed(prod_r[PROD_W-1:15]);
  assign w_nxt    = sat24(26'(x_r) + 26'(prod_q15));
  assign y_nxt    = sat24(26'(d_r) - 26'(prod_q15));

  // Configuration, smoother and pointer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      gain_r   <= '0;
      s_r      <= '0;
      wp_r     <= '0;
      wrap_r   <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_TARGET_DELAY)) begin
        target_r <= cfg_data[TARGET_W-1:0];
      end
      if (cfg_we && (cfg_index == CFG_FEEDBACK_GAIN)) begin
        gain_r <= $signed(cfg_data[GAIN_W-1:0]);
      end
      if (cmd.smooth) begin
        s_r  <= smooth_sum[53:16];
        wp_r <= wp_inc;
      end
      if (cmd.write_w && (wp_r == '0)) begin
        wrap_r <= 1'b1;
      end
    end
  end

  // Working registers, loaded step by step
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r   <= in_audio_in;
      lfo_r <= in_mod_offset;
    end
    if (cmd.calc_off) begin
      v_r <= v_full[TAP_CALC_W-1:0];
    end
    if (cmd.calc_quot) begin
      q_r <= qprod[35:18];
    end
    if (cmd.calc_tap) begin
      tap_r <= tap_nxt;
    end
    if (cmd.mem_rd) begin
      rd_ok_r <= rd_ok_nxt;
    end
    if (cmd.mul_d || cmd.mul_w) begin
      prod_r <= prod_nxt;
    end
    if (cmd.mul_d) begin
      d_r <= d_sel;
    end
    if (cmd.write_w) begin
      w_r <= w_nxt;
      if (tap_r == wp_r) begin
        d_r <= w_nxt;
      end
    end
    if (cmd.load_out) begin
      out_r <= y_nxt;
    end
  end

  // Delay line: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write_w) begin
      mem[wp_r] <= w_nxt;
    end
    if (cmd.mem_rd) begin
      rd_r <= mem[tap_r];
    end
  end

  assign out_audio_out = out_r;

  // Reciprocal quotient is off by at most one
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc_tap |-> (int'(rem) < 2 * DELAY_DEPTH))
    else $error("tap remainder outside one correction step");

  // Read address stays inside the delay line
  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_rd |-> (int'(tap_r) < DELAY_DEPTH))
    else $error("tap index beyond delay depth");

endmodule

// File: src/modulated_allpass_delay.sv
// Top level of the modulated allpass delay: sequencer plus datapath.
//
// Usage: one audio word in, one allpass word out. The input channel carries
// in_audio_in (Q1.23) and in_mod_offset (Q13.8 LFO offset); a word is taken
// when in_valid is high and in_stall low. The output channel presents
// out_audio_out under out_valid, taken when out_stall is low.
// Configuration writes (index 0 target delay, index 1 feedback gain) are
// always taken; write them only while no word is in flight.
// The result is registered in the output register at the last step of the
// sequence. Words are taken one at a time: the step sequencer runs the smoother,
// tap arithmetic, memory read, a gain multiply, the memory write and a second
// gain multiply on the one shared multiplier in turn before it takes the next word.
// Reset clears the smoother, write pointer and configuration registers; the delay line is
// not swept, unwritten entries read as zero through a fill tracker, so the
// block takes words straight after reset.
// A stalled result holds in the output register; the next input word is still
// taken, and its sequence waits at the last step until the output is free.
module modulated_allpass_delay #(
  parameter int DELAY_DEPTH = 16384
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [mad_pkg::SAMPLE_W-1:0]   in_audio_in,
  input  logic signed [mad_pkg::LFO_W-1:0]      in_mod_offset,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mad_pkg::SAMPLE_W-1:0]   out_audio_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [mad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [mad_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mad_pkg::*;

  mad_cmd_t cmd;
  logic     cfg_we;

  // Configuration is taken at any time
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  mad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_o     (cmd)
  );

  mad_dp #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_audio_in   (in_audio_in),
    .in_mod_offset (in_mod_offset),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_audio_out (out_audio_out)
  );

endmodule
